@@ hdl/rdc_pkg.sv @@
// Shared types and constants for the radix digit converter.
// Used by the front queue, the back end and the top level.
package rdc_pkg;

  // Widths fixed by the item fields.
  localparam int unsigned VALUE_IN_W = 32;
  localparam int unsigned RADIX_W    = 5;
  localparam int unsigned DIGIT_W    = 4;

  // Legal base range.
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  // Depth of the request queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // How the front end classified a request.
  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_ZERO   = 2'd1,
    KIND_BAD    = 2'd2
  } item_kind_e;

  // Control part of a queued request; the value travels beside it.
  typedef struct packed {
    item_kind_e         kind;
    logic [RADIX_W-1:0] radix;
  } item_ctl_t;

endpackage

@@ hdl/rdc_front.sv @@
// Front end: accepts requests, classifies the base and value, and holds
// them in a two-entry queue for the back end. Depends on rdc_pkg.
module rdc_front import rdc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  logic [VALUE_IN_W-1:0]  value_i,
  input  logic [RADIX_W-1:0]     radix_i,
  output logic                   q_valid_o,
  input  logic                   q_pop_i,
  output logic [VALUE_WIDTH-1:0] q_value_o,
  output item_ctl_t              q_ctl_o
);

  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);

  logic [VALUE_WIDTH-1:0] val_w;
  item_ctl_t              ctl_w;
  logic                   push, pop;

  logic [VALUE_WIDTH-1:0] val_q [QUEUE_DEPTH];
  item_ctl_t              ctl_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0]      fill_q, fill_d;

  // Keep only the low VALUE_WIDTH bits of the value, zero-extend if wider.
  generate
    if (VALUE_WIDTH <= VALUE_IN_W) begin : g_trunc
      assign val_w = value_i[VALUE_WIDTH-1:0];
    end else begin : g_ext
      assign val_w = {{(VALUE_WIDTH - VALUE_IN_W){1'b0}}, value_i};
    end
  endgenerate

  // Classify the request: an illegal base wins over a zero value.
  always_comb begin
    ctl_w.radix = radix_i;
    if (radix_i < RADIX_MIN || radix_i > RADIX_MAX) begin
      ctl_w.kind = KIND_BAD;
    end else if (val_w == '0) begin
      ctl_w.kind = KIND_ZERO;
    end else begin
      ctl_w.kind = KIND_NORMAL;
    end
  end

  // Queue handshake.
  assign stall_o   = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign push      = valid_i && !stall_o;
  assign q_valid_o = (fill_q != '0);
  assign pop       = q_pop_i && q_valid_o;
  assign q_value_o = val_q[rd_ptr_q];
  assign q_ctl_o   = ctl_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      val_q[wr_ptr_q] <= val_w;
      ctl_q[wr_ptr_q] <= ctl_w;
    end
  end

endmodule

@@ hdl/rdc_div.sv @@
// Bit-serial restoring divider: divides a VALUE_WIDTH-bit quotient register
// by a base of up to 16, one quotient bit per cycle. Depends on rdc_pkg.
module rdc_div import rdc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [RADIX_W-1:0]     divisor_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [DIGIT_W-1:0]     remainder_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] quot_q, quot_d;
  logic [DIGIT_W-1:0]     rem_q, rem_d;
  logic [RADIX_W-1:0]     div_q;
  logic [RADIX_W-1:0]     trial, diff;
  logic                   ge;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   busy_q, busy_d, done_q, done_d;

  // One restoring step: the remainder stays below the divisor, so it fits
  // in a digit.
  assign trial = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign ge    = (trial >= div_q);
  assign diff  = trial - div_q;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(VALUE_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[VALUE_WIDTH-2:0], ge};
      rem_d  = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      quot_q <= quot_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Remainder and divisor are payload.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quot_q;
  assign remainder_o = rem_q;

endmodule

@@ hdl/rdc_back.sv @@
// Back end: runs the divider per digit, stacks the remainders in a small
// memory and pops them into the output register. Depends on rdc_pkg, rdc_div.
module rdc_back import rdc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_pop_o,
  input  logic [VALUE_WIDTH-1:0] q_value_i,
  input  item_ctl_t              q_ctl_i,
  output logic                   valid_o,
  input  logic                   stall_i,
  output logic [DIGIT_W-1:0]     digit_o,
  output logic                   last_o,
  output logic                   bad_radix_o
);

  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_DIV     = 5'b00010,
    ST_POP_RD  = 5'b00100,
    ST_POP_OUT = 5'b01000,
    ST_SINGLE  = 5'b10000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [CNT_W-1:0]       cnt_q, cnt_d, cnt_m1;
  logic                   bad_q, bad_d;
  logic                   div_start, div_busy, div_done;
  logic [VALUE_WIDTH-1:0] div_dividend, div_quot;
  logic [DIGIT_W-1:0]     div_rem;
  logic [RADIX_W-1:0]     radix_q;

  logic [DIGIT_W-1:0]     stack_mem [STACK_DEPTH];
  logic                   st_we, st_re;
  logic [DIGIT_W-1:0]     rd_q;

  logic                   out_free, out_load;
  logic                   out_valid_q, out_valid_d;
  logic [DIGIT_W-1:0]     out_digit_q, out_digit_d;
  logic                   out_last_q, out_last_d, out_bad_q, out_bad_d;

  rdc_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (state_q == ST_IDLE ? q_ctl_i.radix : radix_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot),
    .remainder_o(div_rem)
  );

  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign out_free = !out_valid_q || !stall_i;

  // Sequencer: divide until the quotient is zero, then pop the stack; a zero value or a bad base gives one result.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    bad_d        = bad_q;
    q_pop_o      = 1'b0;
    div_start    = 1'b0;
    div_dividend = q_value_i;
    st_we        = 1'b0;
    st_re        = 1'b0;
    out_load     = 1'b0;
    out_digit_d  = out_digit_q;
    out_last_d   = out_last_q;
    out_bad_d    = out_bad_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cnt_d   = '0;
          if (q_ctl_i.kind == KIND_NORMAL) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            bad_d   = (q_ctl_i.kind == KIND_BAD);
            state_d = ST_SINGLE;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // A remainder beyond the stack depth is dropped.
          if (cnt_q < CNT_W'(STACK_DEPTH)) begin
            st_we = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (div_quot == '0) begin
            state_d = ST_POP_RD;
          end else begin
            div_dividend = div_quot;
            div_start    = 1'b1;
          end
        end
      end
      ST_POP_RD: begin
        st_re   = 1'b1;
        cnt_d   = cnt_m1;
        state_d = ST_POP_OUT;
      end
      ST_POP_OUT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_digit_d = rd_q;
          out_last_d  = (cnt_q == '0);
          out_bad_d   = 1'b0;
          state_d     = (cnt_q == '0) ? ST_IDLE : ST_POP_RD;
        end
      end
      ST_SINGLE: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_digit_d = '0;
          out_last_d  = 1'b1;
          out_bad_d   = bad_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: holds while stalled.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_digit_q <= out_digit_d;
      out_last_q  <= out_last_d;
      out_bad_q   <= out_bad_d;
    end
    if (state_q == ST_IDLE && q_valid_i) begin
      radix_q <= q_ctl_i.radix;
    end
  end

  // Digit stack memory with registered read.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      stack_mem[cnt_q[AW-1:0]] <= div_rem;
    end
    if (st_re) begin
      rd_q <= stack_mem[cnt_m1[AW-1:0]];
    end
  end

  assign valid_o     = out_valid_q;
  assign digit_o     = out_digit_q;
  assign last_o      = out_last_q;
  assign bad_radix_o = out_bad_q;

`ifndef SYNTHESIS
  // A flagged result is always the only one of its request.
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && bad_radix_o) |-> last_o)
    else $error("bad radix result without last");

  // The divider is never restarted while still working.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // A pop never happens on an empty stack.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP_RD) |-> (cnt_q != '0))
    else $error("pop from empty digit stack");

  // The fill count never exceeds the stack depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(STACK_DEPTH))
    else $error("digit count above stack depth");

  // Finishing the last digit returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (state_q == ST_IDLE))
    else $error("sequencer busy after last digit");
`endif

endmodule

@@ hdl/radix_digit_converter.sv @@
// Top level of the radix digit converter.
// Instantiates rdc_front and rdc_back; depends on rdc_pkg.
//
// Converts an unsigned value into its digits in a base from 2 to 16 and
// sends them out most significant first, one result per digit, with last
// set on the final digit. A zero value gives the single digit 0; a base
// outside 2..16 gives one result with bad_radix set. Requests enter a
// two-entry queue, so a new request is taken while an earlier one is being
// converted. The bit-serial divider sets the rate: each digit costs a full
// division, and popping it costs a stack read and an output load; zero
// values and bad bases skip the division.
module radix_digit_converter import rdc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [VALUE_IN_W-1:0] value_i,
  input  logic [RADIX_W-1:0]    radix_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic [DIGIT_W-1:0]    digit_o,
  output logic                  last_o,
  output logic                  bad_radix_o
);

  logic                   q_valid, q_pop;
  logic [VALUE_WIDTH-1:0] q_value;
  item_ctl_t              q_ctl;

  rdc_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_i),
    .stall_o  (stall_o),
    .value_i  (value_i),
    .radix_i  (radix_i),
    .q_valid_o(q_valid),
    .q_pop_i  (q_pop),
    .q_value_o(q_value),
    .q_ctl_o  (q_ctl)
  );

  rdc_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_value_i  (q_value),
    .q_ctl_i    (q_ctl),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .digit_o    (digit_o),
    .last_o     (last_o),
    .bad_radix_o(bad_radix_o)
  );

endmodule

@@ bench/radix_digit_checker.sv @@
// Checker for the radix digit converter: watches both channels, predicts the
// digit sequence of every accepted request and compares each accepted digit.
// Depends on rdc_pkg for the field widths and the legal base range.
module radix_digit_checker import rdc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  req_stall_i,
  input  logic [VALUE_IN_W-1:0] req_value_i,
  input  logic [RADIX_W-1:0]    req_radix_i,
  input  logic                  res_valid_i,
  input  logic                  res_stall_i,
  input  logic [DIGIT_W-1:0]    res_digit_i,
  input  logic                  res_last_i,
  input  logic                  res_bad_radix_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               bad_radix;
  } digit_result_t;

  // Digits still owed by the block, oldest first.
  digit_result_t expected_digits[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Converts one request the way the block must: repeated division pushes
  // remainders on a stack, which is then popped most significant first.
  function automatic void predict_digits(input logic [VALUE_IN_W-1:0] value,
                                         input logic [RADIX_W-1:0]    radix);
    logic [VALUE_WIDTH-1:0] quotient;
    logic [VALUE_WIDTH-1:0] remainder;
    logic [DIGIT_W-1:0]     stack [STACK_DEPTH];
    int unsigned            depth;
    digit_result_t          entry;

    quotient = VALUE_WIDTH'(value);
    depth    = 0;
    // A base outside the legal range wins over everything else.
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      entry = '{digit: '0, last: 1'b1, bad_radix: 1'b1};
      expected_digits.push_back(entry);
      return;
    end
    if (quotient == '0) begin
      entry = '{digit: '0, last: 1'b1, bad_radix: 1'b0};
      expected_digits.push_back(entry);
      return;
    end
    // Remainders beyond the stack depth are dropped, the division goes on.
    while (quotient != '0) begin
      remainder = quotient % radix;
      quotient  = quotient / radix;
      if (depth < STACK_DEPTH) begin
        stack[depth] = remainder[DIGIT_W-1:0];
        depth++;
      end
    end
    while (depth > 0) begin
      depth--;
      entry = '{digit: stack[depth], last: (depth == 0), bad_radix: 1'b0};
      expected_digits.push_back(entry);
    end
  endfunction

  task automatic report_failure(input string what, input digit_result_t want,
                                input digit_result_t got);
    if (fail_count_o < 10) begin
      $display("%t: %s: expected digit %0d last %0b bad_radix %0b,",
               $realtime, what, want.digit, want.last, want.bad_radix);
      $display("    got digit %0d last %0b bad_radix %0b",
               got.digit, got.last, got.bad_radix);
    end
    fail_count_o++;
  endtask

  // Requests are predicted before digits are checked, so a digit accepted
  // at the same edge as its own request would still find its expectation.
  always @(posedge clk_i) begin
    digit_result_t got;
    digit_result_t want;

    if (rst_ni) begin
      if (req_valid_i && !req_stall_i) begin
        predict_digits(req_value_i, req_radix_i);
      end
      if (res_valid_i && !res_stall_i) begin
        got = '{digit: res_digit_i, last: res_last_i, bad_radix: res_bad_radix_i};
        if (expected_digits.size() == 0) begin
          report_failure("digit with no request behind it", '0, got);
        end else begin
          want = expected_digits.pop_front();
          if (got !== want) begin
            report_failure("digit mismatch", want, got);
          end
        end
      end
      pending_o = expected_digits.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
// Top of the radix digit converter bench: clock, reset, request and stall
// stimulus, and the final verdict. Depends on rdc_pkg, radix_digit_converter
// and radix_digit_checker.
module testbench import rdc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned RANDOM_ITEMS  = 135;
  localparam int unsigned DRAIN_CYCLES  = 1200;
  localparam logic [VALUE_IN_W-1:0] ALL_ONES = '1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  valid_i;
  logic                  stall_o;
  logic [VALUE_IN_W-1:0] value_i;
  logic [RADIX_W-1:0]    radix_i;
  logic                  valid_o;
  logic                  stall_i;
  logic [DIGIT_W-1:0]    digit_o;
  logic                  last_o;
  logic                  bad_radix_o;

  int unsigned check_failures;
  int unsigned digits_pending;
  int unsigned cycle_count;
  bit          quiet_stretch;

  radix_digit_converter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .value_i     (value_i),
    .radix_i     (radix_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .digit_o     (digit_o),
    .last_o      (last_o),
    .bad_radix_o (bad_radix_o)
  );

  radix_digit_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (valid_i),
    .req_stall_i     (stall_o),
    .req_value_i     (value_i),
    .req_radix_i     (radix_i),
    .res_valid_i     (valid_o),
    .res_stall_i     (stall_i),
    .res_digit_i     (digit_o),
    .res_last_i      (last_o),
    .res_bad_radix_i (bad_radix_o),
    .fail_count_o    (check_failures),
    .pending_o       (digits_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Digit side: before each digit the receiver holds stall for a random
  // number of cycles, except during quiet stretches.
  initial begin
    int unsigned hold;

    stall_i <= 1'b0;
    forever begin
      hold = quiet_stretch ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (!valid_o);
    end
  end

  // Presents one request after a random gap and holds it until taken.
  // Valid is only lowered when a gap follows, so back-to-back requests
  // keep it high.
  task automatic send_request(input logic [VALUE_IN_W-1:0] value,
                              input logic [RADIX_W-1:0]    radix);
    int unsigned gap;

    gap = quiet_stretch ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    value_i <= value;
    radix_i <= radix;
    do @(posedge clk_i); while (stall_o);
  endtask

  initial begin
    logic [VALUE_IN_W-1:0] value;
    logic [RADIX_W-1:0]    radix;
    int unsigned           bits;

    quiet_stretch = 1'b0;
    rst_ni  <= 1'b0;
    valid_i <= 1'b0;
    value_i <= '0;
    radix_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: zero values, the widest and narrowest conversions,
    // and bad bases at both ends of the field, zero value among them.
    send_request('0, 5'd10);
    send_request('0, 5'd0);
    send_request(ALL_ONES, RADIX_MIN);
    send_request(ALL_ONES, RADIX_MAX);
    send_request(32'd1, RADIX_MIN);
    send_request(32'h8000_0000, 5'd31);
    send_request(32'd12345, 5'd1);
    send_request(32'd55, 5'd17);
    send_request(ALL_ONES, 5'd3);
    send_request(32'd16, RADIX_MAX);
    for (int r = RADIX_MIN; r <= RADIX_MAX; r++) begin
      send_request($urandom, RADIX_W'(r));
    end

    // Random part: mostly short values so the run stays quick, a quarter
    // at full width, and one base in eight outside the legal range.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 20 == 0) begin
        quiet_stretch = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 3) == 0) begin
        value = $urandom;
      end else begin
        bits  = $urandom_range(0, 16);
        value = $urandom & ((VALUE_IN_W'(1) << bits) - 1);
      end
      if ($urandom_range(0, 7) == 0) begin
        radix = RADIX_W'($urandom_range(0, 16));
        if (radix >= RADIX_MIN) begin
          radix = radix + 5'd15;
        end
      end else begin
        radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
      end
      send_request(value, radix);
    end
    valid_i <= 1'b0;
    quiet_stretch = 1'b0;

    // Drain: wait for every owed digit, then watch for stray ones.
    do @(negedge clk_i); while (digits_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (check_failures == 0 && digits_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
